### design/hse_pkg.sv
// Huffman stream encoder package: action codes, register indexes, FSM states
// and the command/status structs between controller and datapath.
// No dependencies.
package hse_pkg;

    // Input actions
    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FINISH = 2'd2
    } action_t;

    // Configuration register indexes
    localparam logic [0:0] REG_END_BITS = 1'b0;
    localparam logic [0:0] REG_END_LEN  = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_RUN,
        ST_PAD
    } state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic tbl_write;   // store a table entry
        logic tbl_read;    // read a table entry
        logic load_entry;  // align table code into the shifter
        logic load_end;    // align end code into the shifter
        logic emit;        // send one full byte
        logic absorb;      // move leftover code bits into pending bits
        logic pad;         // send padded final byte and clear
        logic finish;      // current transaction is a finish
    } hse_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic avail_ge8;   // at least one full byte available
        logic avail_nz;    // any bits available
        logic out_free;    // output register can take a byte
    } hse_status_t;

endpackage

### design/hse_ctrl.sv
// Huffman stream encoder controller: sequences lookup, byte emission,
// absorb and padding. Depends on hse_pkg.
module hse_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          action,
    input  hse_pkg::hse_status_t st,
    output hse_pkg::hse_cmd_t    cmd
);

    hse_pkg::state_t state_reg;
    hse_pkg::state_t state_next;
    logic            fin_reg;
    logic            fin_next;
    logic            accept;

    assign accept = in_valid && in_ready;

    // State and finish flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hse_pkg::ST_IDLE;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        unique case (state_reg)
            hse_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    fin_next = (action == hse_pkg::ACT_FINISH);
                    if (action == hse_pkg::ACT_ENCODE)
                        state_next = hse_pkg::ST_LOOKUP;
                    else if (action == hse_pkg::ACT_FINISH)
                        state_next = hse_pkg::ST_RUN;
                end
            end
            hse_pkg::ST_LOOKUP:
                state_next = hse_pkg::ST_RUN;
            hse_pkg::ST_RUN:
            begin
                if (!st.avail_ge8)
                begin
                    if (fin_reg && st.avail_nz)
                        state_next = hse_pkg::ST_PAD;
                    else
                        state_next = hse_pkg::ST_IDLE;
                end
            end
            hse_pkg::ST_PAD:
            begin
                if (st.out_free)
                    state_next = hse_pkg::ST_IDLE;
            end
            default:
                state_next = hse_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.finish     = fin_reg;
        unique case (state_reg)
            hse_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.tbl_write = accept && (action == hse_pkg::ACT_LOAD);
                cmd.tbl_read  = accept && (action == hse_pkg::ACT_ENCODE);
                cmd.load_end  = accept && (action == hse_pkg::ACT_FINISH);
            end
            hse_pkg::ST_LOOKUP:
                cmd.load_entry = 1'b1;
            hse_pkg::ST_RUN:
            begin
                cmd.emit   = st.avail_ge8 && st.out_free;
                cmd.absorb = !st.avail_ge8;
            end
            hse_pkg::ST_PAD:
                cmd.pad = st.out_free;
            default:
                in_ready = 1'b0;
        endcase
    end

`ifndef ASSERT_OFF
    // An accepted encode always goes through a table lookup
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == hse_pkg::ACT_ENCODE) |=> state_reg == hse_pkg::ST_LOOKUP)
        else $error("encode did not enter lookup");

    // Padding belongs to finish transactions only
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hse_pkg::ST_PAD) |-> fin_reg)
        else $error("pad state outside finish");

    // Lookup always moves on to run
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hse_pkg::ST_LOOKUP) |=> (state_reg == hse_pkg::ST_RUN))
        else $error("lookup did not move on to run");
`endif

endmodule

### design/hse_datapath.sv
// Huffman stream encoder datapath: code table memory, config registers,
// code shifter, pending-bit accumulator and output register. Depends on hse_pkg.
module hse_datapath
#(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hse_pkg::hse_cmd_t    cmd,
    output hse_pkg::hse_status_t st,
    input  logic [7:0]           symbol,
    input  logic [5:0]           code_length,
    input  logic [31:0]          code_bits,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [31:0]          cfg_wdata,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 run_last,
    output logic                 stream_end
);

    localparam int W   = MAX_CODE_LEN;
    localparam int CW  = $clog2(MAX_CODE_LEN + 1);
    localparam int AVW = CW + 1;
    localparam int AW  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int EW  = CW + 32;

    // Table memory and lookup
    logic [EW-1:0]  mem [SYMBOL_COUNT];
    logic [EW-1:0]  rd_data_reg;
    logic           sym_ok_reg;
    logic           sym_ok;
    logic [AW-1:0]  addr;

    // Config registers
    logic [31:0]    end_bits_reg;
    logic [5:0]     end_len_reg;

    // Shifter and accumulator
    logic [W-1:0]   shreg_reg;
    logic [CW-1:0]  rem_reg;
    logic [6:0]     pb_reg;
    logic [2:0]     pc_reg;

    // Output register
    logic           out_valid_reg;
    logic [7:0]     out_byte_reg;
    logic           run_last_reg;
    logic           stream_end_reg;

    logic [CW-1:0]  len_sel;
    logic [31:0]    code_sel;
    logic [W-1:0]   code_ext;
    logic [CW-1:0]  sh_amt;
    logic [7:0]     top8;
    logic [AVW-1:0] avail;
    logic [3:0]     take;
    logic [7:0]     emit_byte;
    logic [7:0]     absorb_byte;
    logic [2:0]     rem3;
    logic           emit_last;
    logic           emit_end;
    logic           out_free;

    function automatic logic [CW-1:0] clamp_len(input logic [5:0] len);
        if (len > 6'(MAX_CODE_LEN))
            return CW'(MAX_CODE_LEN);
        else
            return CW'(len);
    endfunction

    assign sym_ok = ({1'b0, symbol} < 9'(SYMBOL_COUNT));
    assign addr   = symbol[AW-1:0];

    // Table write
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_write && sym_ok)
            mem[addr] <= {clamp_len(code_length), code_bits};
    end

    // Table read, registered
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_read)
        begin
            rd_data_reg <= mem[addr];
            sym_ok_reg  <= sym_ok;
        end
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_bits_reg <= '0;
            end_len_reg  <= 6'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hse_pkg::REG_END_BITS: end_bits_reg <= cfg_wdata;
                hse_pkg::REG_END_LEN:  end_len_reg  <= cfg_wdata[5:0];
                default:               end_bits_reg <= end_bits_reg;
            endcase
        end
    end

    // Left-align the selected code in the shifter
    always_comb
    begin
        if (cmd.load_end)
        begin
            len_sel  = clamp_len(end_len_reg);
            code_sel = end_bits_reg;
        end
        else
        begin
            len_sel  = sym_ok_reg ? rd_data_reg[EW-1:32] : '0;
            code_sel = rd_data_reg[31:0];
        end
    end

    assign code_ext = W'(code_sel);
    assign sh_amt   = CW'(MAX_CODE_LEN) - len_sel;

    // Byte assembly from pending bits and top of shifter
    assign top8        = shreg_reg[W-1 -: 8];
    assign avail       = AVW'(rem_reg) + AVW'(pc_reg);
    assign take        = 4'd8 - {1'b0, pc_reg};
    assign emit_byte   = 8'({1'b0, pb_reg} << take) | (top8 >> pc_reg);
    assign rem3        = rem_reg[2:0];
    assign absorb_byte = 8'({1'b0, pb_reg} << rem3) | 8'(top8 >> (4'd8 - {1'b0, rem3}));
    assign emit_end    = cmd.finish && (avail == AVW'(8));
    assign emit_last   = cmd.finish ? emit_end : (avail < AVW'(16));
    assign out_free    = !out_valid_reg || out_ready;

    // Shifter and accumulator update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shreg_reg <= '0;
            rem_reg   <= '0;
            pb_reg    <= '0;
            pc_reg    <= '0;
        end
        else
        begin
            priority if (cmd.load_end || cmd.load_entry)
            begin
                shreg_reg <= code_ext << sh_amt;
                rem_reg   <= len_sel;
            end
            else if (cmd.emit)
            begin
                // pending bits go out with the first byte
                shreg_reg <= shreg_reg << take;
                rem_reg   <= rem_reg - CW'(take);
                pb_reg    <= '0;
                pc_reg    <= '0;
            end
            else if (cmd.absorb)
            begin
                rem_reg <= '0;
                if (cmd.finish && avail == '0)
                begin
                    pb_reg <= '0;
                    pc_reg <= '0;
                end
                else
                begin
                    pb_reg <= absorb_byte[6:0];
                    pc_reg <= pc_reg + rem3;
                end
            end
            else if (cmd.pad)
            begin
                pb_reg <= '0;
                pc_reg <= '0;
            end
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit || cmd.pad)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_byte_reg   <= emit_byte;
            run_last_reg   <= emit_last;
            stream_end_reg <= emit_end;
        end
        else if (cmd.pad)
        begin
            out_byte_reg   <= 8'({1'b0, pb_reg} << take);
            run_last_reg   <= 1'b1;
            stream_end_reg <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign run_last   = run_last_reg;
    assign stream_end = stream_end_reg;

    assign st.avail_ge8 = (avail >= AVW'(8));
    assign st.avail_nz  = (avail != '0);
    assign st.out_free  = out_free;

`ifndef ASSERT_OFF
    // A byte is only loaded into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit || cmd.pad) |-> out_free)
        else $error("output register overwritten");

    // Padding only happens with bits pending
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pad |-> (pc_reg != 3'd0))
        else $error("pad with no pending bits");

    // Absorb drains the shifter completely
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.absorb |=> (rem_reg == '0))
        else $error("code bits left after absorb");
`endif

endmodule

### design/huffman_stream_encoder.sv
// Channel    Dir  Handshake            Payload
// in         in   in_valid/in_ready    action, symbol, code_length, code_bits
// out        out  out_valid/out_ready  out_byte, run_last, stream_end
// cfg        in   cfg_we               cfg_index, cfg_wdata
//
// Load writes one table entry. Encode steps through table read, align,
// one byte per cycle through the code shifter while the output is free,
// and an absorb step; finish aligns the end code, then emits, absorbs and
// pads a final byte when bits remain. One transaction at a time; the output
// register stalls the shifter when out_ready is low. Reset clears pending
// bits and control and resets config; table entries are undefined until loaded.
module huffman_stream_encoder
#(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  symbol,
    input  logic [5:0]  code_length,
    input  logic [31:0] code_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        stream_end,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    hse_pkg::hse_cmd_t    cmd;
    hse_pkg::hse_status_t st;

    // Controller
    hse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath
    hse_datapath #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .symbol      (symbol),
        .code_length (code_length),
        .code_bits   (code_bits),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .stream_end  (stream_end)
    );

endmodule
